// ===== rtl/madp_pkg.sv =====
// ----------------------------------------------------------------------------
// madp_pkg
// Shared types and constants of the multichannel adaptive delta predictor.
// ----------------------------------------------------------------------------
package madp_pkg;

   localparam int unsigned NUM_WEIGHTS = 5;
   localparam int unsigned NUM_HIST    = 4;
   localparam int unsigned NUM_SUMS    = 11;

   localparam logic [2:0] COUNT_DEFAULT = 3'd1;
   localparam logic [2:0] COUNT_LIMIT   = 3'd4;

   // Complete per-channel state, kept as one word of the channel memory.
   typedef struct packed {
      logic [NUM_WEIGHTS-1:0][5:0] weights;
      logic [NUM_HIST-1:0][8:0]    hist;
      logic [7:0]                  prev_delta;
      logic [8:0]                  prev_value;
      logic [NUM_SUMS-1:0][15:0]   sums;
      logic [4:0]                  count;
   } chan_state_type;

endpackage

// ===== rtl/madp_calc.sv =====
// ----------------------------------------------------------------------------
// madp_calc
// Combinational datapath: prediction, sample, history, error sums and weight
// adaptation for the channel in flight.
// ----------------------------------------------------------------------------
module madp_calc
   import madp_pkg::*;
(
   input  chan_state_type cur_state,
   input  logic [7:0]     cross_delta,
   input  logic [7:0]     delta,
   output chan_state_type nxt_state,
   output logic [7:0]     sample,
   output logic [7:0]     cross_delta_nxt
);

   function automatic logic [10:0] mag12(input logic [11:0] v);
      logic [11:0] neg;
      begin
         neg = 12'd0 - v;
         return v[11] ? neg[10:0] : v[10:0];
      end
   endfunction

   // Keeps the lower index on a tie.
   function automatic logic [19:0] min_pair(input logic [19:0] lo, input logic [19:0] hi);
      return (hi[15:0] < lo[15:0]) ? hi : lo;
   endfunction

   logic [4:0][8:0]   terms;
   logic [4:0][14:0]  prods;
   logic [10:0]       acc;
   logic [8:0]        sample9;
   logic [8:0]        step_delta;
   logic [11:0]       err12;
   logic [10:0][15:0] sums_add;
   logic [10:0][19:0] cand;
   logic [5:0][19:0]  lvl1;
   logic [2:0][19:0]  lvl2;
   logic [1:0][19:0]  lvl3;
   logic [19:0]       best;
   logic [3:0]        best_idx;
   logic [3:0]        best_m1;
   logic [2:0]        w_sel;
   logic [4:0]        count_nxt;
   logic              roll;

   always_comb begin
      // History shift: the newest term is the last delta, then its change.
      terms[0] = {cur_state.prev_delta[7], cur_state.prev_delta};
      terms[1] = terms[0] - cur_state.hist[0];
      terms[2] = cur_state.hist[1];
      terms[3] = cur_state.hist[2];
      terms[4] = {cross_delta[7], cross_delta};

      for (int k = 0; k < 5; k++) begin
         prods[k] = 15'($signed(cur_state.weights[k]) * $signed(terms[k]));
      end

      // Only bits 3 to 10 of the weighted sum are used, so 11 bits suffice.
      acc = {cur_state.prev_value[7:0], 3'b000} + prods[0][10:0] + prods[1][10:0]
          + prods[2][10:0] + prods[3][10:0] + prods[4][10:0];
      sample9 = {1'b0, acc[10:3]} - {1'b0, delta};
      step_delta = sample9 - cur_state.prev_value;

      err12 = {delta[7], delta, 3'b000};
      sums_add[0] = cur_state.sums[0] + 16'(mag12(err12));
      for (int k = 0; k < 5; k++) begin
         sums_add[2*k+1] = cur_state.sums[2*k+1]
                         + 16'(mag12(err12 - {{3{terms[k][8]}}, terms[k]}));
         sums_add[2*k+2] = cur_state.sums[2*k+2]
                         + 16'(mag12(err12 + {{3{terms[k][8]}}, terms[k]}));
      end

      for (int k = 0; k < 11; k++) begin
         cand[k] = {4'(k), sums_add[k]};
      end
      for (int k = 0; k < 5; k++) begin
         lvl1[k] = min_pair(cand[2*k], cand[2*k+1]);
      end
      lvl1[5] = cand[10];
      for (int k = 0; k < 3; k++) begin
         lvl2[k] = min_pair(lvl1[2*k], lvl1[2*k+1]);
      end
      lvl3[0] = min_pair(lvl2[0], lvl2[1]);
      lvl3[1] = lvl2[2];
      best = min_pair(lvl3[0], lvl3[1]);
      best_idx = best[19:16];
      best_m1 = best_idx - 4'd1;
      w_sel = best_m1[3:1];

      count_nxt = cur_state.count + 5'd1;
      roll = (count_nxt == 5'd0);

      nxt_state.hist[0]   = terms[0];
      nxt_state.hist[1]   = terms[1];
      nxt_state.hist[2]   = terms[2];
      nxt_state.hist[3]   = terms[3];
      nxt_state.prev_delta = step_delta[7:0];
      nxt_state.prev_value = sample9;
      nxt_state.count      = count_nxt;
      nxt_state.sums       = roll ? '0 : sums_add;

      // Every 32 samples the best-scoring term moves its weight one step, unless the plain sum scores best.
      for (int k = 0; k < 5; k++) begin
         nxt_state.weights[k] = cur_state.weights[k];
         if (roll && (best_idx != 4'd0) && (w_sel == 3'(k))) begin
            if (best_idx[0]) begin
               if ($signed(cur_state.weights[k]) >= -6'sd16) begin
                  nxt_state.weights[k] = cur_state.weights[k] - 6'd1;
               end
            end else begin
               if ($signed(cur_state.weights[k]) < 6'sd16) begin
                  nxt_state.weights[k] = cur_state.weights[k] + 6'd1;
               end
            end
         end
      end
   end

   assign sample          = sample9[7:0];
   assign cross_delta_nxt = step_delta[7:0];

endmodule

// ===== rtl/multichannel_adaptive_delta_predictor_top.sv =====
// Pipeline: an accepted delta beat passes stage 1, then the sample register, whose beat is offered.
// Throughput: one delta beat per cycle while the sample side takes its beats; the channel
// memory is read at acceptance and written back when stage 1 moves on, with the
// written-back state forwarded to a following beat of the same channel.
// Reset: synchronous, active high; control registers take their reset values and the per-channel
// valid bits clear at once, so every channel reads as zero state; no clearing pass.
// ----------------------------------------------------------------------------
// multichannel_adaptive_delta_predictor_top
// Interleaved multichannel adaptive delta predictor. Each delta beat yields one
// sample beat for the channel whose turn it is; channels rotate round-robin.
// ----------------------------------------------------------------------------
module multichannel_adaptive_delta_predictor_top
   import madp_pkg::*;
#(
   parameter int unsigned MAX_CHANNELS = 4
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_delta,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_sample,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data
);

   localparam int unsigned CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam logic [3:0]  MAX_CH = 4'(MAX_CHANNELS);

   // Channel state memory: one word per channel, synchronous read. An entry
   // that has never been written reads as all zero through its valid bit.
   chan_state_type            chan_mem [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0]   mem_valid_ff;
   chan_state_type            rd_data_ff;
   logic                      rd_valid_ff;

   logic [2:0]      ccount_ff;
   logic [CH_W-1:0] active_ch_ff;
   logic [CH_W-1:0] active_ch_in;
   logic [7:0]      cross_ff;

   // Stage 1: the beat whose channel word is being read, then computed.
   logic            s1_valid_ff;
   logic [CH_W-1:0] s1_ch_ff;
   logic [7:0]      s1_delta_ff;
   logic            s1_fwd_ff;
   chan_state_type  wb_state_ff;

   logic            rsp_valid_ff;
   logic [7:0]      rsp_sample_ff;

   logic            req_accept;
   logic            s1_fire;
   logic [3:0]      eff_count;
   logic [3:0]      wr_eff_count;
   logic [3:0]      ch_plus1;
   chan_state_type  cur_state;
   chan_state_type  nxt_state;
   logic [7:0]      calc_sample;
   logic [7:0]      calc_cross;

   // A zero count behaves as one channel; counts above four saturate, and
   // never beyond the channels that the memory holds.
   function automatic logic [3:0] limit_count(input logic [2:0] raw);
      logic [3:0] n;
      begin
         n = {1'b0, raw};
         if (raw == 3'd0) begin
            n = {1'b0, COUNT_DEFAULT};
         end else if (raw > COUNT_LIMIT) begin
            n = {1'b0, COUNT_LIMIT};
         end
         if (n > MAX_CH) begin
            n = MAX_CH;
         end
         return n;
      end
   endfunction

   assign eff_count    = limit_count(ccount_ff);
   assign wr_eff_count = limit_count(csr_wr_data);

   // The output register decouples the two sides: stage 1 moves on whenever the
   // sample register is empty or its beat is taken in the same cycle.
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_fire;
   assign req_accept = req_valid && req_ready;

   assign ch_plus1     = 4'(active_ch_ff) + 4'd1;
   assign active_ch_in = (ch_plus1 >= eff_count) ? '0 : CH_W'(ch_plus1);

   // A beat of the same channel accepted while its predecessor writes back
   // reads a stale word, so it takes the written-back copy instead.
   always_comb begin
      if (s1_fwd_ff) begin
         cur_state = wb_state_ff;
      end else if (rd_valid_ff) begin
         cur_state = rd_data_ff;
      end else begin
         cur_state = '0;
      end
   end

   madp_calc u_calc (
      .cur_state       (cur_state),
      .cross_delta     (cross_ff),
      .delta           (s1_delta_ff),
      .nxt_state       (nxt_state),
      .sample          (calc_sample),
      .cross_delta_nxt (calc_cross)
   );

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         chan_mem[s1_ch_ff] <= nxt_state;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= chan_mem[active_ch_ff];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         ccount_ff    <= COUNT_DEFAULT;
         active_ch_ff <= '0;
         cross_ff     <= 8'd0;
         s1_valid_ff  <= 1'b0;
         s1_fwd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ccount_ff <= csr_wr_data;
            if (4'(active_ch_ff) >= wr_eff_count) begin
               active_ch_ff <= '0;
            end
         end else if (req_accept) begin
            active_ch_ff <= active_ch_in;
         end

         if (s1_fire) begin
            mem_valid_ff[s1_ch_ff] <= 1'b1;
            cross_ff               <= calc_cross;
         end

         if (req_accept) begin
            rd_valid_ff <= mem_valid_ff[active_ch_ff];
            s1_fwd_ff   <= s1_fire && (s1_ch_ff == active_ch_ff);
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
            s1_fwd_ff   <= 1'b0;
         end

         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ch_ff    <= active_ch_ff;
         s1_delta_ff <= req_delta;
      end
      if (s1_fire) begin
         wb_state_ff   <= nxt_state;
         rsp_sample_ff <= calc_sample;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

`ifndef SYNTHESIS
   a_active_in_range: assert property (@(posedge clock) disable iff (reset)
      4'(active_ch_ff) < eff_count)
      else $error("active channel beyond the configured count");

   a_fwd_has_beat: assert property (@(posedge clock) disable iff (reset)
      s1_fwd_ff |-> s1_valid_ff)
      else $error("forward flag set without a beat in stage 1");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(s1_ch_ff)))
      else $error("stalled stage 1 beat lost or changed channel");

   a_ready_reason: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input held off while the pipeline has room");
`endif

endmodule

// ===== bench/tb_multichannel_adaptive_delta_predictor_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multichannel_adaptive_delta_predictor_top
// Self-checking bench for the interleaved adaptive delta predictor. Delta beats
// are fed through a valid/ready driver. Every accepted beat is run through a
// behavioural copy of the predictor, and each sample beat is compared with the
// oldest forecast. The channel count is reprogrammed between drained phases.
// ----------------------------------------------------------------------------
module tb_multichannel_adaptive_delta_predictor_top;
   import madp_pkg::*;

   localparam int CHANNELS   = 4;
   localparam int WEIGHT_MAX = 16;
   localparam int WEIGHT_MIN = -17;
   localparam int RANDOM_ITEMS = 1650;

   // Flavours of delta content used by the random phases.
   typedef enum int {
      STYLE_UNIFORM,
      STYLE_SMALL,
      STYLE_STEADY,
      STYLE_WALK
   } delta_style_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_delta = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_sample;
   logic       csr_wr_en = 1'b0;
   logic [2:0] csr_wr_data = 3'd0;

   multichannel_adaptive_delta_predictor_top #(
      .MAX_CHANNELS(CHANNELS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_delta  (req_delta),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Deltas waiting to be offered, and the samples forecast for the beats
   // that the block has already accepted.
   logic [7:0] queued_deltas[$];
   logic [7:0] predicted_samples[$];
   // Deltas queued but not yet accepted; counted separately from the queue
   // so that a beat sitting on the bus still keeps the bench busy.
   int         deltas_outstanding = 0;
   int         sample_errors = 0;
   int         drv_hold = 0;
   int         drv_calm = 0;
   int         rsp_hold = 0;
   int         rsp_calm = 0;

   // Behavioural copy of the predictor state. Everything but the channel count starts at zero,
   // which matches the state the block presents straight after reset.
   int         weight_q  [CHANNELS][NUM_WEIGHTS];
   int         hist_q    [CHANNELS][NUM_HIST];
   int         err_sum_q [CHANNELS][NUM_SUMS];
   int         last_delta_q [CHANNELS];
   int         last_value_q [CHANNELS];
   int         sample_cnt_q [CHANNELS];
   int         cross_delta_q = 0;
   int         active_ch_q = 0;
   logic [2:0] chan_count_q = COUNT_DEFAULT;

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // A count of zero behaves as one channel; anything above the limit
   // saturates.
   function automatic int eff_count();
      int n;
      n = int'(chan_count_q);
      if (n == 0) n = 1;
      if (n > int'(COUNT_LIMIT)) n = int'(COUNT_LIMIT);
      if (n > CHANNELS) n = CHANNELS;
      return n;
   endfunction

   // Advances the channel whose turn it is by one delta and returns the
   // sample that the block must produce for it.
   function automatic logic [7:0] predict_sample(input logic [7:0] delta);
      int         ch, acc, scaled, smp, diff, term, least, best, wi, j, k;
      logic [7:0] pred, low_byte;
      ch = active_ch_q;
      if (ch >= eff_count()) ch = 0;
      sample_cnt_q[ch] = (sample_cnt_q[ch] + 1) & 32'h1F;

      // Shift the delta history: h1 is the change of the last delta.
      hist_q[ch][3] = hist_q[ch][2];
      hist_q[ch][2] = hist_q[ch][1];
      hist_q[ch][1] = last_delta_q[ch] - hist_q[ch][0];
      hist_q[ch][0] = last_delta_q[ch];

      acc = 8 * last_value_q[ch];
      for (j = 0; j < NUM_HIST; j++) acc += weight_q[ch][j] * hist_q[ch][j];
      acc += weight_q[ch][NUM_WEIGHTS-1] * cross_delta_q;
      pred = acc[10:3];
      smp = int'(pred) - int'(delta);

      // Error sums: the signed delta scaled by 8, against each history
      // term and the cross-channel delta, both signs.
      scaled = int'($signed(delta)) * 8;
      err_sum_q[ch][0] = (err_sum_q[ch][0] + magnitude(scaled)) & 32'hFFFF;
      for (k = 1; k < NUM_SUMS; k++) begin
         j = (k - 1) >> 1;
         term = (j < NUM_HIST) ? hist_q[ch][j] : cross_delta_q;
         term = (k & 1) ? scaled - term : scaled + term;
         err_sum_q[ch][k] = (err_sum_q[ch][k] + magnitude(term)) & 32'hFFFF;
      end

      diff = smp - last_value_q[ch];
      low_byte = diff[7:0];
      last_delta_q[ch] = int'($signed(low_byte));
      cross_delta_q = last_delta_q[ch];
      last_value_q[ch] = smp;

      // Once every 32 samples the smallest sum steers one weight; ties go
      // to the lowest index and the plain sum leaves the weights alone.
      if (sample_cnt_q[ch] == 0) begin
         least = err_sum_q[ch][0];
         best = 0;
         for (k = 1; k < NUM_SUMS; k++) begin
            if (err_sum_q[ch][k] < least) begin
               least = err_sum_q[ch][k];
               best = k;
            end
         end
         for (k = 0; k < NUM_SUMS; k++) err_sum_q[ch][k] = 0;
         if (best != 0) begin
            wi = (best - 1) >> 1;
            if (best & 1) begin
               if (weight_q[ch][wi] > WEIGHT_MIN) weight_q[ch][wi]--;
            end else begin
               if (weight_q[ch][wi] < WEIGHT_MAX) weight_q[ch][wi]++;
            end
         end
      end

      ch++;
      if (ch >= eff_count()) ch = 0;
      active_ch_q = ch;
      return smp[7:0];
   endfunction

   // Idle lengths: mostly none or short, occasionally long, with stretches
   // of back-to-back traffic now and then.
   function automatic int draw_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 199);
      if (roll < 3) begin
         calm = $urandom_range(40, 160);
         return 0;
      end
      if (roll < 100) return 0;
      if (roll < 170) return $urandom_range(1, 3);
      if (roll < 194) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] draw_delta(input delta_style_type style,
                                             input logic [7:0] level);
      case (style)
         STYLE_SMALL:  return 8'($urandom_range(0, 16) - 32'd8);
         STYLE_STEADY: return level;
         STYLE_WALK:   return level + 8'($urandom_range(0, 4)) - 8'd2;
         default:      return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Driver: offers queued deltas and holds each beat until it is taken.
   // The forecast is made at the very edge at which the beat is accepted.
   always @(posedge clock) begin : delta_driver
      if (reset) begin
         req_valid <= 1'b0;
         req_delta <= 8'd0;
         drv_hold = 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_samples.push_back(predict_sample(req_delta));
            deltas_outstanding--;
            drv_hold = draw_gap(drv_calm);
         end
         if (!req_valid || req_ready) begin
            if (drv_hold > 0) begin
               drv_hold--;
               req_valid <= 1'b0;
            end else if (queued_deltas.size() != 0) begin
               req_valid <= 1'b1;
               req_delta <= queued_deltas.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each sample beat against the oldest forecast and then
   // stalls the response side for a random while.
   always @(posedge clock) begin : sample_monitor
      logic [7:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_samples.size() == 0) begin
               if (sample_errors < 10)
                  $display("%0t: sample beat 0x%02h with nothing forecast",
                           $realtime, rsp_sample);
               sample_errors++;
            end else begin
               want = predicted_samples.pop_front();
               if (rsp_sample !== want) begin
                  if (sample_errors < 10)
                     $display("%0t: sample mismatch, expected 0x%02h, got 0x%02h",
                              $realtime, want, rsp_sample);
                  sample_errors++;
               end
            end
            rsp_hold = draw_gap(rsp_calm);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   task automatic queue_delta(input logic [7:0] delta);
      queued_deltas.push_back(delta);
      deltas_outstanding++;
   endtask

   task automatic queue_phase(input int count, input delta_style_type style);
      logic [7:0] level;
      level = 8'($urandom_range(1, 7));
      if ($urandom_range(0, 1)) level = -level;
      repeat (count) queue_delta(draw_delta(style, level));
   endtask

   // Returns once every queued delta has been accepted and every forecast
   // sample has come back.
   task automatic wait_drained();
      do @(posedge clock);
      while (deltas_outstanding != 0 || predicted_samples.size() != 0);
   endtask

   // The register is only ever touched with the block idle. Lowering the
   // count below the channel in turn sends the rotation back to channel 0.
   task automatic write_channel_count(input logic [2:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      chan_count_q = value;
      if (active_ch_q >= eff_count()) active_ch_q = 0;
   endtask

   initial begin : stimulus
      int              total;
      int              length;
      delta_style_type style;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Field extremes and sign boundaries on the default single channel.
      // The leading zeros leave every error sum tied.
      queue_delta(8'd0);   queue_delta(8'd0);   queue_delta(8'd255);
      queue_delta(8'd128); queue_delta(8'd127); queue_delta(8'd1);
      queue_delta(8'd254); queue_delta(8'd8);

      // A count of zero must behave as one channel.
      write_channel_count(3'd0);
      queue_delta(8'd16);  queue_delta(8'd240); queue_delta(8'd85);

      // The largest count saturates at four channels; six beats leave the
      // rotation on channel 2.
      write_channel_count(3'd7);
      queue_delta(8'd170); queue_delta(8'd255); queue_delta(8'd0);
      queue_delta(8'd128); queue_delta(8'd127); queue_delta(8'd64);

      // Dropping to two channels while channel 2 is next restarts at 0.
      write_channel_count(3'd2);
      queue_delta(8'd200); queue_delta(8'd3);   queue_delta(8'd252);
      queue_delta(8'd129); queue_delta(8'd126);

      // Four channels, walk the rotation to channel 3, then fall to one.
      write_channel_count(COUNT_LIMIT);
      queue_delta(8'd32);  queue_delta(8'd224);
      write_channel_count(COUNT_DEFAULT);

      // A long steady run on one channel keeps nudging the same weight,
      // long enough to pin it against its limit.
      total = 600;
      queue_phase(total, STYLE_STEADY);

      // Random phases: mixed counts and content, mostly short phases.
      while (total < RANDOM_ITEMS) begin
         write_channel_count(3'($urandom_range(0, 7)));
         length = $urandom_range(10, 120);
         case ($urandom_range(0, 3))
            0:       style = STYLE_UNIFORM;
            1:       style = STYLE_SMALL;
            2:       style = STYLE_STEADY;
            default: style = STYLE_WALK;
         endcase
         queue_phase(length, style);
         total += length;
      end

      // Drain, then let any stray beat show itself before the verdict.
      wait_drained();
      repeat (8) @(posedge clock);
      if (sample_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
